@@ rtl/core/gb5_pkg.sv @@
// Shared types and constants for the 5x5 binomial blur.
// No dependencies; imported by gb5_tap5, gb5_pos and the blur top level.
`default_nettype none

package gb5_pkg;

  // Default frame limits, handed to the top level as parameter defaults
  localparam int GB5_MAX_WIDTH  = 512;
  localparam int GB5_MAX_HEIGHT = 512;

  // Kernel geometry
  localparam int KS     = 5;
  localparam int NLINES = 4;
  localparam int HALO   = 4;

  // Word widths
  localparam int PIX_W  = 8;
  localparam int CFG_W  = 10;
  localparam int CIDX_W = 1;
  localparam int LINE_W = NLINES * PIX_W;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // Per-word position flags travelling down the pipeline
  typedef struct packed {
    logic border;     // first four rows or columns: pass through
    logic last;       // last pixel of the frame
  } gb5_tag_t;

  typedef logic [PIX_W-1:0] pix_t;

endpackage

`default_nettype wire

@@ rtl/core/gb5_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies. Read data holds while rd_en is low.
`default_nettype none

module gb5_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 512,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/gb5_tap5.sv @@
// Five-tap binomial weighted sum (1 4 6 4 1), combinational.
// Depends on gb5_pkg; used for both the row and the column pass.
`default_nettype none

module gb5_tap5
  import gb5_pkg::*;
#(
  parameter int IN_W = 8
) (
  input  wire logic [KS-1:0][IN_W-1:0] tap,
  output logic      [IN_W+3:0]         sum
);

  logic [IN_W+3:0] t0, t1, t2, t3, t4;

  // weights 1 4 6 4 1 as shifts and adds
  always_comb begin
    t0  = (IN_W+4)'(tap[0]);
    t1  = (IN_W+4)'(tap[1]) << 2;
    t2  = ((IN_W+4)'(tap[2]) << 2) + ((IN_W+4)'(tap[2]) << 1);
    t3  = (IN_W+4)'(tap[3]) << 2;
    t4  = (IN_W+4)'(tap[4]);
    sum = (t0 + t4) + (t1 + t3) + t2;
  end

endmodule

`default_nettype wire

@@ rtl/core/gb5_pos.sv @@
// Frame size registers and row/column position counters.
// Depends on gb5_pkg; flags border and last-of-frame for each accepted word.
`default_nettype none

module gb5_pos
  import gb5_pkg::*;
#(
  parameter int MAX_WIDTH  = GB5_MAX_WIDTH,
  parameter int MAX_HEIGHT = GB5_MAX_HEIGHT,
  parameter int CCNT_W     = $clog2(MAX_WIDTH)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              step,
  output logic      [CCNT_W-1:0] col,
  output gb5_tag_t               tag
);

  localparam int RCNT_W = $clog2(MAX_HEIGHT);
  localparam int WL_W   = (CCNT_W + 1 > CFG_W) ? CCNT_W + 1 : CFG_W;
  localparam int HL_W   = (RCNT_W + 1 > CFG_W) ? RCNT_W + 1 : CFG_W;

  logic [WL_W-1:0]   width_r;
  logic [HL_W-1:0]   height_r;
  logic [WL_W-1:0]   wlim;
  logic [HL_W-1:0]   hlim;
  logic [CCNT_W-1:0] col_r, col_nxt;
  logic [RCNT_W-1:0] row_r, row_nxt;
  logic              col_wrap, row_wrap;

  // size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WL_W'(MAX_WIDTH);
      height_r <= HL_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  width_r  <= WL_W'(cfg_data);
        CFG_FRAME_HEIGHT: height_r <= HL_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // last column / row index: zero acts as one, oversize as the maximum
  always_comb begin
    if (width_r == '0) begin
      wlim = '0;
    end else if (width_r > WL_W'(MAX_WIDTH)) begin
      wlim = WL_W'(MAX_WIDTH - 1);
    end else begin
      wlim = width_r - 1'b1;
    end
    if (height_r == '0) begin
      hlim = '0;
    end else if (height_r > HL_W'(MAX_HEIGHT)) begin
      hlim = HL_W'(MAX_HEIGHT - 1);
    end else begin
      hlim = height_r - 1'b1;
    end
  end

  // counter step; a counter past a shrunk limit wraps on its next step
  always_comb begin
    col_wrap = WL_W'(col_r) >= wlim;
    row_wrap = HL_W'(row_r) >= hlim;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (col_wrap) begin
      col_nxt = '0;
      row_nxt = row_wrap ? '0 : row_r + 1'b1;
    end else begin
      col_nxt = col_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (step) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col        = col_r;
  assign tag.border = (row_r < RCNT_W'(HALO)) || (col_r < CCNT_W'(HALO));
  assign tag.last   = col_wrap && row_wrap;

endmodule

`default_nettype wire

@@ rtl/core/gaussian_blur_5x5_stream.sv @@
// 5x5 binomial blur on a raster pixel stream: one word out for each word in.
// Words pass stages 1 to 3 and the output register; one word per cycle sustained while
// out_stall is low, set by the single line store RAM port pair (one read, one write per cycle).
// Synchronous active-low reset clears counters, size registers and valids;
// line store and window contents are not cleared and are undefined until written.
// Depends on gb5_pkg, gb5_pos, gb5_ram and gb5_tap5.
`default_nettype none

module gaussian_blur_5x5_stream
  import gb5_pkg::*;
#(
  parameter int MAX_WIDTH  = GB5_MAX_WIDTH,
  parameter int MAX_HEIGHT = GB5_MAX_HEIGHT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration write
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  // pixel input
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [PIX_W-1:0]  in_pixel_in,
  // pixel output
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [PIX_W-1:0]  out_pixel_out,
  output logic                   out_frame_end
);

  localparam int CCNT_W = $clog2(MAX_WIDTH);
  localparam int HS_W   = PIX_W + 4;
  localparam int VS_W   = HS_W + 4;

  logic              accept;
  logic [CCNT_W-1:0] cur_col;
  gb5_tag_t          cur_tag;

  // stage 1: line store read in flight
  logic              s1_valid_r;
  pix_t              s1_px_r;
  logic [CCNT_W-1:0] s1_col_r;
  gb5_tag_t          s1_tag_r;
  logic              s1_byp_r;
  logic [LINE_W-1:0] s1_bypdata_r;
  logic [LINE_W-1:0] ram_rd_data;
  logic [LINE_W-1:0] column;
  logic [LINE_W-1:0] ram_wr_data;

  // stage 2: window
  logic              s2_valid_r;
  pix_t              window_r [KS][KS];
  pix_t              s2_px_r;
  gb5_tag_t          s2_tag_r;

  // stage 3: row sums
  logic              s3_valid_r;
  logic [HS_W-1:0]   hsum_r [KS];
  logic [HS_W-1:0]   hsum [KS];
  pix_t              s3_px_r;
  gb5_tag_t          s3_tag_r;
  logic [VS_W-1:0]   vsum;
  logic [KS-1:0][HS_W-1:0] vtap;

  // output register
  logic              out_valid_r;
  pix_t              out_pixel_r;
  logic              out_last_r;

  logic o_free, s3_adv, s3_free, s2_adv, s2_free, s1_adv, s1_free;

  // flow control: each stage moves when the next one is empty or moving
  always_comb begin
    o_free  = !out_valid_r || !out_stall;
    s3_adv  = s3_valid_r && o_free;
    s3_free = !s3_valid_r || o_free;
    s2_adv  = s2_valid_r && s3_free;
    s2_free = !s2_valid_r || s3_free;
    s1_adv  = s1_valid_r && s2_free;
    s1_free = !s1_valid_r || s2_free;
  end

  assign in_stall  = !s1_free;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  gb5_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CCNT_W     (CCNT_W)
  ) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (accept),
    .col       (cur_col),
    .tag       (cur_tag)
  );

  // four line stores packed in one word per column, oldest line in the low byte
  gb5_ram #(
    .DATA_W (LINE_W),
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (CCNT_W)
  ) u_lines (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (ram_wr_data),
    .rd_en   (accept),
    .rd_addr (cur_col),
    .rd_data (ram_rd_data)
  );

  // same-column write in the read cycle (single-column frames) is forwarded
  assign column      = s1_byp_r ? s1_bypdata_r : ram_rd_data;
  assign ram_wr_data = {s1_px_r, column[LINE_W-1:PIX_W]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r      <= in_pixel_in;
      s1_col_r     <= cur_col;
      s1_tag_r     <= cur_tag;
      s1_byp_r     <= s1_adv && (s1_col_r == cur_col);
      s1_bypdata_r <= ram_wr_data;
    end
  end

  // stage 2: shift the window left, new column on the right
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int i = 0; i < KS; i++) begin
        for (int j = 0; j < KS - 1; j++) begin
          window_r[i][j] <= window_r[i][j+1];
        end
      end
      for (int i = 0; i < NLINES; i++) begin
        window_r[i][KS-1] <= column[i*PIX_W +: PIX_W];
      end
      window_r[KS-1][KS-1] <= s1_px_r;
      s2_px_r  <= s1_px_r;
      s2_tag_r <= s1_tag_r;
    end
  end

  // horizontal pass, one five-tap sum per window row
  for (genvar gi = 0; gi < KS; gi++) begin : g_row
    logic [KS-1:0][PIX_W-1:0] rtap;
    for (genvar gj = 0; gj < KS; gj++) begin : g_tap
      assign rtap[gj] = window_r[gi][gj];
    end
    gb5_tap5 #(.IN_W(PIX_W)) u_hsum (
      .tap (rtap),
      .sum (hsum[gi])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_free) begin
      s3_valid_r <= s2_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      for (int i = 0; i < KS; i++) begin
        hsum_r[i] <= hsum[i];
      end
      s3_px_r  <= s2_px_r;
      s3_tag_r <= s2_tag_r;
    end
  end

  // vertical pass over the row sums; total weight 256
  for (genvar gv = 0; gv < KS; gv++) begin : g_vtap
    assign vtap[gv] = hsum_r[gv];
  end

  gb5_tap5 #(.IN_W(HS_W)) u_vsum (
    .tap (vtap),
    .sum (vsum)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_free) begin
      out_valid_r <= s3_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      out_pixel_r <= s3_tag_r.border ? s3_px_r : vsum[PIX_W+7:8];
      out_last_r  <= s3_tag_r.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_frame_end = out_last_r;

endmodule

`default_nettype wire

@@ tb/gaussian_blur_5x5_stream_test.sv @@
// Self-checking testbench for gaussian_blur_5x5_stream: random-burst pixel
// driver, stalling receiver and an in-bench 5x5 binomial blur predictor.
// Depends on gb5_pkg and the gaussian_blur_5x5_stream RTL.
`timescale 1ns / 100ps

module gaussian_blur_5x5_stream_test;
  import gb5_pkg::*;

  localparam int unsigned MAX_W = GB5_MAX_WIDTH;
  localparam int unsigned MAX_H = GB5_MAX_HEIGHT;
  localparam int unsigned BINOM [KS] = '{1, 4, 6, 4, 1};

  typedef struct packed {
    pix_t pixel;
    logic frame_end;
  } blur_word_t;

  typedef struct packed {
    logic [CIDX_W-1:0] idx;
    logic [CFG_W-1:0]  val;
  } size_write_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  pix_t              in_pixel_in = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  pix_t              out_pixel_out;
  logic              out_frame_end;

  gaussian_blur_5x5_stream uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out),
    .out_frame_end (out_frame_end)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stimulus, expectations and pending size writes
  pix_t        pixel_feed_q [$];
  blur_word_t  blurred_due_q [$];
  size_write_t reg_writes_q [$];

  // Predictor copy of the block: sizes, position, line history and window
  logic [CFG_W-1:0] width_reg = CFG_W'(MAX_W);
  logic [CFG_W-1:0] height_reg = CFG_W'(MAX_H);
  int unsigned      row_pos = 0;
  int unsigned      col_pos = 0;
  pix_t             row_hist [NLINES][MAX_W];
  pix_t             tap_win [KS][KS];

  int unsigned fault_count = 0;
  int unsigned words_seen = 0;

  // Zero acts as one, anything past the maximum as the maximum
  function automatic int unsigned eff_size(input logic [CFG_W-1:0] v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  task automatic log_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endtask

  // One pixel through the blur: shift line history and window, work out the word
  task automatic predict_blur(input pix_t px);
    pix_t        col_taps [NLINES];
    int unsigned c, r, w, h, acc;
    blur_word_t  due;
    w = eff_size(width_reg, MAX_W);
    h = eff_size(height_reg, MAX_H);
    c = (col_pos >= MAX_W) ? 0 : col_pos;
    r = row_pos;
    for (int i = 0; i < NLINES; i++) col_taps[i] = row_hist[i][c];
    for (int i = 0; i < NLINES - 1; i++) row_hist[i][c] = col_taps[i+1];
    row_hist[NLINES-1][c] = px;
    for (int i = 0; i < KS; i++)
      for (int j = 0; j < KS - 1; j++) tap_win[i][j] = tap_win[i][j+1];
    for (int i = 0; i < NLINES; i++) tap_win[i][KS-1] = col_taps[i];
    tap_win[KS-1][KS-1] = px;
    if (r < HALO || c < HALO) begin
      due.pixel = px;
    end else begin
      acc = 0;
      for (int i = 0; i < KS; i++)
        for (int j = 0; j < KS; j++) acc += tap_win[i][j] * BINOM[i] * BINOM[j];
      due.pixel = pix_t'(acc >> 8);
    end
    due.frame_end = (c + 1 >= w) && (r + 1 >= h);
    // wrap at the limit, even when a shrink left the counter past it
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
    blurred_due_q.push_back(due);
  endtask

  // Sender: bursts of random length with random gaps, payload held while stalled
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_blur(in_pixel_in);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 || pixel_feed_q.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end else begin
          in_valid <= 1'b1;
          in_pixel_in <= pixel_feed_q.pop_front();
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
      end
    end
  end

  // Receiver stall pattern, mode re-chosen at random as stall_tick runs
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned stall_tick = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 64 == 63) stall_mode <= stall_mode_t'($urandom_range(0, 3));
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_COIN:     out_stall <= $urandom_range(0, 1);
        STALL_PERIODIC: out_stall <= (stall_tick % 5) < 2;
        default:        out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Check each accepted word against the oldest expectation
  always @(posedge clk) begin : check_words
    blur_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (blurred_due_q.size() == 0) begin
        log_fault($sformatf("word %0d arrived with nothing expected", words_seen));
      end else begin
        want = blurred_due_q.pop_front();
        if (out_pixel_out !== want.pixel || out_frame_end !== want.frame_end)
          log_fault($sformatf("word %0d: expected pixel %0d end %0b, got pixel %0d end %0b",
                              words_seen, want.pixel, want.frame_end,
                              out_pixel_out, out_frame_end));
      end
    end
  end

  task automatic queue_write(input logic [CIDX_W-1:0] idx, input int unsigned val);
    size_write_t sw;
    sw.idx = idx;
    sw.val = val[CFG_W-1:0];
    reg_writes_q.push_back(sw);
  endtask

  // Issue the queued size writes back to back; valid stays high between them
  task automatic apply_sizes();
    while (reg_writes_q.size() != 0) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_writes_q[0].idx;
      cfg_data <= reg_writes_q[0].val;
      do @(posedge clk); while (!cfg_ready);
      if (reg_writes_q[0].idx == CFG_FRAME_WIDTH) width_reg = reg_writes_q[0].val;
      else if (reg_writes_q[0].idx == CFG_FRAME_HEIGHT) height_reg = reg_writes_q[0].val;
      void'(reg_writes_q.pop_front());
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_noise(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) pixel_feed_q.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
      else pixel_feed_q.push_back($urandom_range(0, 255));
    end
  endtask

  // Wait until the feed queue is empty, the sender is idle and every expected word is back
  task automatic wait_drained();
    do @(posedge clk);
    while (pixel_feed_q.size() != 0 || in_valid || blurred_due_q.size() != 0);
  endtask

  initial begin
    int unsigned fed, n, v, w, h, rem;
    bit          at_start;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    fed = 0;

    // Directed: bit patterns at the reset size of 512 x 512
    pixel_feed_q.push_back(8'h00);
    pixel_feed_q.push_back(8'hFF);
    pixel_feed_q.push_back(8'h55);
    pixel_feed_q.push_back(8'hAA);
    fed += 4;
    wait_drained();

    // zero sizes mid-frame: column counter sits past the new limit and wraps
    queue_write(CFG_FRAME_WIDTH, 0);
    queue_write(CFG_FRAME_HEIGHT, 0);
    apply_sizes();
    pixel_feed_q.push_back(8'h0F);
    pixel_feed_q.push_back(8'hF0);
    pixel_feed_q.push_back(8'h80);
    fed += 3;
    wait_drained();

    // smallest frame with a blurred pixel, all white: sum hits its ceiling
    queue_write(CFG_FRAME_WIDTH, 5);
    queue_write(CFG_FRAME_HEIGHT, 5);
    apply_sizes();
    repeat (25) pixel_feed_q.push_back(8'hFF);
    fed += 25;
    wait_drained();

    // oversize both: a full 512-pixel row and four more, then shrink width to finish all 512 rows
    queue_write(CFG_FRAME_WIDTH, 1023);
    queue_write(CFG_FRAME_HEIGHT, 1023);
    apply_sizes();
    queue_noise(516);
    fed += 516;
    wait_drained();
    queue_write(CFG_FRAME_WIDTH, 0);
    apply_sizes();
    n = eff_size(height_reg, MAX_H) - row_pos;
    queue_noise(n);
    fed += n;
    wait_drained();

    // Random phases; width only shrinks within a frame so no unwritten line is read
    while (fed < 1400) begin
      at_start = (row_pos == 0 && col_pos == 0);
      if ($urandom_range(0, 3) != 0) begin
        if (at_start) begin
          case ($urandom_range(0, 15))
            0:       v = 0;
            1:       v = 1;
            2:       v = $urandom_range(512, 1023);
            3:       v = $urandom_range(20, 120);
            default: v = $urandom_range(4, 16);
          endcase
        end else begin
          v = $urandom_range(0, eff_size(width_reg, MAX_W));
        end
        queue_write(CFG_FRAME_WIDTH, v);
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 15))
          0:       v = 0;
          1:       v = $urandom_range(513, 1023);
          2:       v = 1;
          default: v = $urandom_range(4, 12);
        endcase
        queue_write(CFG_FRAME_HEIGHT, v);
      end
      apply_sizes();

      // mostly run to the end of the frame, sometimes one more, sometimes cut short
      w = eff_size(width_reg, MAX_W);
      h = eff_size(height_reg, MAX_H);
      rem = ((col_pos + 1 >= w) ? 1 : w - col_pos) +
            ((row_pos + 1 >= h) ? 0 : (h - 1 - row_pos) * w);
      case ($urandom_range(0, 3))
        0:       n = $urandom_range(1, 40);
        1:       n = rem + w * h;
        default: n = rem;
      endcase
      if (n > 120) n = $urandom_range(40, 120);
      queue_noise(n);
      wait_drained();
      fed += n;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (blurred_due_q.size() != 0)
      log_fault($sformatf("%0d expected words never arrived", blurred_due_q.size()));
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
